// ===== design/bfs_pkg.sv =====
// Shared types, widths and helpers for the bending-force stencil block.
// Used by bfs_scale and bending_force_stencil_top; depends on nothing else.
`default_nettype none

package bfs_pkg;

  localparam int COORD_W  = 32;                    // Q16.16 coordinate and force width
  localparam int IDX_W    = 6;                     // width of the point_index result field
  localparam int NUM_AXES = 3;                     // axes carried by the payload structs
  localparam int DIFF_W   = 34;                    // exact second difference
  localparam int HALF_W   = 16;                    // rigidity is multiplied one half at a time
  localparam int PROD_W   = DIFF_W + HALF_W + 1;   // signed product of difference and half
  localparam int FRC_W    = PROD_W;                // width of one stencil term f
  localparam int ACC_W    = 54;                    // exact sum of a force and its stencil terms

  localparam int TRIPLET_REACH   = 2;              // a triplet spans its start and two more
  localparam int LOOP_MIN_POINTS = 4;              // ring closure needs this many points

  localparam int PADDR_W     = 3;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_RIGIDITY  = 1'b0;
  localparam logic REG_LOOP_MODE = 1'b1;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] force_in_x;
    logic signed [COORD_W-1:0] force_in_y;
    logic signed [COORD_W-1:0] force_in_z;
    logic                      last_point;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] force_out_x;
    logic signed [COORD_W-1:0] force_out_y;
    logic signed [COORD_W-1:0] force_out_z;
    logic [IDX_W-1:0]          point_index;
    logic                      overflow;
    logic                      last_result;
  } out_t;

  // Step control for the shared scaling unit.
  typedef struct packed {
    logic capture_lo;   // register the product with the low half of the rigidity
    logic sel_hi;       // multiply by the high half and combine with the stored product
  } scl_ctrl_t;

  // Clamp an exact sum to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[ACC_W-1:COORD_W-1];
    all_zero = ~|v[ACC_W-1:COORD_W-1];
    if (all_one || all_zero) begin
      return v[COORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/bfs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the position and force stores of the stencil block.
`default_nettype none

module bfs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                   wdata,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bfs_scale.sv =====
// Shared scaling unit: forms the second difference of three coordinates and
// multiplies it by the rigidity in two half-width steps. Depends on bfs_pkg.
`default_nettype none

module bfs_scale (
  input  wire                                     clk,
  input  wire bfs_pkg::scl_ctrl_t                 ctrl,
  input  wire signed [bfs_pkg::COORD_W-1:0]       xa,
  input  wire signed [bfs_pkg::COORD_W-1:0]       xb,
  input  wire signed [bfs_pkg::COORD_W-1:0]       xc,
  input  wire [bfs_pkg::COORD_W-1:0]              rigidity,
  output logic signed [bfs_pkg::FRC_W-1:0]        f
);

  localparam int EXT_W = bfs_pkg::DIFF_W - bfs_pkg::COORD_W;

  logic signed [bfs_pkg::DIFF_W-1:0] xa_e;
  logic signed [bfs_pkg::DIFF_W-1:0] xb_e;
  logic signed [bfs_pkg::DIFF_W-1:0] xc_e;
  logic signed [bfs_pkg::DIFF_W-1:0] diff;
  logic [bfs_pkg::HALF_W-1:0]        r_half;
  logic signed [bfs_pkg::PROD_W-1:0] prod;
  logic signed [bfs_pkg::PROD_W-1:0] prod_r;

  assign xa_e = {{EXT_W{xa[bfs_pkg::COORD_W-1]}}, xa};
  assign xb_e = {{EXT_W{xb[bfs_pkg::COORD_W-1]}}, xb};
  assign xc_e = {{EXT_W{xc[bfs_pkg::COORD_W-1]}}, xc};
  assign diff = xa_e - (xb_e <<< 1) + xc_e;

  assign r_half = ctrl.sel_hi ? rigidity[bfs_pkg::COORD_W-1:bfs_pkg::HALF_W]
                              : rigidity[bfs_pkg::HALF_W-1:0];
  assign prod   = diff * $signed({1'b0, r_half});

  always_ff @(posedge clk) begin
    if (ctrl.capture_lo) begin
      prod_r <= prod;
    end
  end

  // The high-half product is already a multiple of 2^16, so the floor of the
  // full product over 2^16 is that product plus the shifted low-half product.
  assign f = prod + (prod_r >>> bfs_pkg::HALF_W);

endmodule

`default_nettype wire

// ===== design/bending_force_stencil_top.sv =====
// Bending-force stencil top level: point stores, sequencer and output register.
// Depends on bfs_pkg, bfs_ram and bfs_scale. Points load one per cycle; after the
// last point each result needs three RAM reads, then three steps per axis through the
// one shared multiplier; in ring mode with four or more points, two wrap triplets are
// first computed once per fiber. Inputs stall until the final result is handed over.
// Synchronous active-low reset clears control state; the stores need no clearing.
`default_nettype none

module bending_force_stencil_top #(
  parameter int MAX_POINTS = 64,
  parameter int DIMENSION  = 3
) (
  input  wire                              clk,
  input  wire                              rst_n,

  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire bfs_pkg::in_t                in_data,

  output logic                             out_valid,
  input  wire                              out_stall,
  output bfs_pkg::out_t                    out_data,

  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire [bfs_pkg::PADDR_W-1:0]       cfg_paddr,
  input  wire [31:0]                       cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int AXW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
  localparam int CWD = bfs_pkg::COORD_W;
  localparam int PW  = DIMENSION * CWD;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RD   = 6'b000010,
    S_LO   = 6'b000100,
    S_HI   = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    JOB_PT = 3'b001,   // stencil term starting at the current point
    JOB_A  = 3'b010,   // wrap triplet last, first, second
    JOB_B  = 3'b100    // wrap triplet second to last, last, first
  } job_t;

  function automatic logic signed [bfs_pkg::ACC_W-1:0] ext_f(
    input logic signed [bfs_pkg::FRC_W-1:0] v);
    return {{(bfs_pkg::ACC_W - bfs_pkg::FRC_W){v[bfs_pkg::FRC_W-1]}}, v};
  endfunction

  function automatic logic signed [bfs_pkg::ACC_W-1:0] ext_c(
    input logic signed [CWD-1:0] v);
    return {{(bfs_pkg::ACC_W - CWD){v[CWD-1]}}, v};
  endfunction

  // Control state.
  state_t           state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [1:0]       rd_r, rd_nxt;
  logic [AXW-1:0]   ax_r, ax_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CWD-1:0]   rigidity_r;
  logic             loop_mode_r;

  // Datapath registers.
  logic signed [CWD-1:0]            p0_r [DIMENSION];
  logic signed [CWD-1:0]            p0_nxt [DIMENSION];
  logic signed [CWD-1:0]            p1_r [DIMENSION];
  logic signed [CWD-1:0]            p1_nxt [DIMENSION];
  logic signed [CWD-1:0]            p2_r [DIMENSION];
  logic signed [CWD-1:0]            p2_nxt [DIMENSION];
  logic signed [CWD-1:0]            frc_r [DIMENSION];
  logic signed [CWD-1:0]            frc_nxt [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fm1_r [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fm1_nxt [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fm2_r [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fm2_nxt [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fa_r [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fa_nxt [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fb_r [DIMENSION];
  logic signed [bfs_pkg::FRC_W-1:0] fb_nxt [DIMENSION];
  logic signed [CWD-1:0]            res_r [bfs_pkg::NUM_AXES];
  logic signed [CWD-1:0]            res_nxt [bfs_pkg::NUM_AXES];
  logic signed [bfs_pkg::ACC_W-1:0] part_r, part_nxt;
  logic signed [bfs_pkg::FRC_W-1:0] f_r, f_nxt;
  bfs_pkg::out_t                    out_data_r, out_data_nxt;

  // Stores.
  logic            ram_we;
  logic [PW-1:0]   pos_wdata;
  logic [PW-1:0]   frc_wdata;
  logic [AW-1:0]   pos_raddr;
  logic [PW-1:0]   pos_rdata;
  logic [PW-1:0]   frc_rdata;
  logic signed [CWD-1:0] pos_rd [DIMENSION];
  logic signed [CWD-1:0] frc_rd [DIMENSION];
  logic signed [CWD-1:0] in_pos [bfs_pkg::NUM_AXES];
  logic signed [CWD-1:0] in_frc [bfs_pkg::NUM_AXES];

  // Shared unit.
  bfs_pkg::scl_ctrl_t               scl_ctrl;
  logic signed [bfs_pkg::FRC_W-1:0] scl_f;

  // Helpers.
  logic                             accept_in;
  logic                             room;
  logic [CW-1:0]                    n_new;
  logic                             loop_act;
  logic [CW:0]                      idx_w;
  logic [CW:0]                      n_w;
  logic                             f_valid;
  logic                             is_first;
  logic                             is_second;
  logic                             is_penult;
  logic                             is_last;
  logic                             last_ax;
  logic [AW-1:0]                    nm1;
  logic [AW-1:0]                    nm2;
  logic signed [bfs_pkg::ACC_W-1:0] fa_e;
  logic signed [bfs_pkg::ACC_W-1:0] fb_e;
  logic signed [bfs_pkg::ACC_W-1:0] u_term;
  logic signed [bfs_pkg::ACC_W-1:0] v_term;
  logic                             cfg_wr;

  assign in_pos[0] = in_data.pos_x;
  assign in_pos[1] = in_data.pos_y;
  assign in_pos[2] = in_data.pos_z;
  assign in_frc[0] = in_data.force_in_x;
  assign in_frc[1] = in_data.force_in_y;
  assign in_frc[2] = in_data.force_in_z;

  for (genvar a = 0; a < DIMENSION; a++) begin : g_axis
    assign pos_wdata[a*CWD +: CWD] = in_pos[a];
    assign frc_wdata[a*CWD +: CWD] = in_frc[a];
    assign pos_rd[a] = pos_rdata[a*CWD +: CWD];
    assign frc_rd[a] = frc_rdata[a*CWD +: CWD];
  end

  bfs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  bfs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_frc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (frc_wdata),
    .raddr (idx_r),
    .rdata (frc_rdata)
  );

  assign scl_ctrl.capture_lo = (state_r == S_LO);
  assign scl_ctrl.sel_hi     = (state_r == S_HI);

  bfs_scale u_scale (
    .clk      (clk),
    .ctrl     (scl_ctrl),
    .xa       (p0_r[ax_r]),
    .xb       (p1_r[ax_r]),
    .xc       (p2_r[ax_r]),
    .rigidity (rigidity_r),
    .f        (scl_f)
  );

  assign accept_in = in_valid && !in_stall;
  assign room      = (cnt_r < CW'(MAX_POINTS));
  assign n_new     = room ? (cnt_r + CW'(1)) : cnt_r;
  assign loop_act  = loop_mode_r && (32'(cnt_r) >= bfs_pkg::LOOP_MIN_POINTS);
  assign idx_w     = (CW+1)'(idx_r);
  assign n_w       = (CW+1)'(cnt_r);
  assign f_valid   = (idx_w + (CW+1)'(bfs_pkg::TRIPLET_REACH)) < n_w;
  assign is_first  = (idx_r == '0);
  assign is_second = (idx_r == AW'(1));
  assign is_penult = (idx_w + (CW+1)'(bfs_pkg::TRIPLET_REACH)) == n_w;
  assign is_last   = (idx_w + (CW+1)'(1)) == n_w;
  assign last_ax   = (ax_r == AXW'(DIMENSION - 1));
  assign nm1       = AW'(cnt_r - CW'(1));
  assign nm2       = AW'(cnt_r - CW'(bfs_pkg::TRIPLET_REACH));

  // Position read address for each of the three reads of a job.
  always_comb begin
    pos_raddr = idx_r;
    unique case (job_r)
      JOB_PT: begin
        if (rd_r == 2'd0)      pos_raddr = idx_r;
        else if (rd_r == 2'd1) pos_raddr = idx_r + AW'(1);
        else                   pos_raddr = idx_r + AW'(bfs_pkg::TRIPLET_REACH);
      end
      JOB_A: begin
        if (rd_r == 2'd0)      pos_raddr = nm1;
        else if (rd_r == 2'd1) pos_raddr = '0;
        else                   pos_raddr = AW'(1);
      end
      JOB_B: begin
        if (rd_r == 2'd0)      pos_raddr = nm2;
        else if (rd_r == 2'd1) pos_raddr = nm1;
        else                   pos_raddr = '0;
      end
      default: pos_raddr = idx_r;
    endcase
  end

  // Ring-closure contributions for the current point and axis. With at least
  // four points, the first, second, second-to-last and last points are distinct.
  always_comb begin
    fa_e   = ext_f(fa_r[ax_r]);
    fb_e   = ext_f(fb_r[ax_r]);
    u_term = '0;
    v_term = '0;
    if (loop_act) begin
      if (is_first) begin
        u_term = fa_e <<< 1;
        v_term = -fb_e;
      end
      if (is_second) begin
        u_term = -fa_e;
      end
      if (is_penult) begin
        v_term = -fb_e;
      end
      if (is_last) begin
        u_term = -fa_e;
        v_term = fb_e <<< 1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    rd_nxt        = rd_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    frc_nxt       = frc_r;
    fm1_nxt       = fm1_r;
    fm2_nxt       = fm2_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    res_nxt       = res_r;
    part_nxt      = part_r;
    f_nxt         = f_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (accept_in) begin
          ram_we = room;
          if (room) begin
            cnt_nxt = n_new;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_point) begin
            state_nxt = S_RD;
            rd_nxt    = '0;
            idx_nxt   = '0;
            ax_nxt    = '0;
            job_nxt   = (loop_mode_r && (32'(n_new) >= bfs_pkg::LOOP_MIN_POINTS))
                        ? JOB_A : JOB_PT;
            for (int a = 0; a < DIMENSION; a++) begin
              fm1_nxt[a] = '0;
              fm2_nxt[a] = '0;
            end
            for (int a = 0; a < bfs_pkg::NUM_AXES; a++) begin
              res_nxt[a] = '0;
            end
          end
        end
      end

      S_RD: begin
        rd_nxt = rd_r + 2'd1;
        unique case (rd_r)
          2'd1: p0_nxt = pos_rd;
          2'd2: p1_nxt = pos_rd;
          2'd3: begin
            p2_nxt    = pos_rd;
            frc_nxt   = frc_rd;
            ax_nxt    = '0;
            state_nxt = S_LO;
          end
          default: ;
        endcase
      end

      S_LO: begin
        part_nxt  = ext_c(frc_r[ax_r]) + u_term + v_term;
        state_nxt = S_HI;
      end

      S_HI: begin
        unique case (job_r)
          JOB_PT: begin
            f_nxt     = f_valid ? scl_f : '0;
            part_nxt  = part_r - ext_f(fm2_r[ax_r]) + (ext_f(fm1_r[ax_r]) <<< 1);
            state_nxt = S_FIN;
          end
          JOB_A: begin
            fa_nxt[ax_r] = scl_f;
            if (last_ax) begin
              job_nxt   = JOB_B;
              rd_nxt    = '0;
              state_nxt = S_RD;
            end else begin
              ax_nxt    = ax_r + AXW'(1);
              state_nxt = S_LO;
            end
          end
          JOB_B: begin
            fb_nxt[ax_r] = scl_f;
            if (last_ax) begin
              job_nxt   = JOB_PT;
              rd_nxt    = '0;
              idx_nxt   = '0;
              state_nxt = S_RD;
            end else begin
              ax_nxt    = ax_r + AXW'(1);
              state_nxt = S_LO;
            end
          end
          default: state_nxt = S_LOAD;
        endcase
      end

      S_FIN: begin
        res_nxt[ax_r] = bfs_pkg::sat32(part_r - ext_f(f_r));
        fm2_nxt[ax_r] = fm1_r[ax_r];
        fm1_nxt[ax_r] = f_r;
        if (last_ax) begin
          state_nxt = S_OUT;
        end else begin
          ax_nxt    = ax_r + AXW'(1);
          state_nxt = S_LO;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.force_out_x = res_r[0];
          out_data_nxt.force_out_y = res_r[1];
          out_data_nxt.force_out_z = res_r[2];
          out_data_nxt.point_index = bfs_pkg::IDX_W'(idx_r);
          out_data_nxt.overflow    = drop_r;
          out_data_nxt.last_result = is_last;
          if (is_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            rd_nxt    = '0;
            ax_nxt    = '0;
            state_nxt = S_RD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      job_r       <= JOB_PT;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      rd_r        <= '0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      rd_r        <= rd_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    frc_r      <= frc_nxt;
    fm1_r      <= fm1_nxt;
    fm2_r      <= fm2_nxt;
    fa_r       <= fa_nxt;
    fb_r       <= fb_nxt;
    res_r      <= res_nxt;
    part_r     <= part_nxt;
    f_r        <= f_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rigidity_r  <= '0;
      loop_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[bfs_pkg::REG_IDX_BIT])
        bfs_pkg::REG_RIGIDITY:  rigidity_r  <= cfg_pwdata;
        bfs_pkg::REG_LOOP_MODE: loop_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[bfs_pkg::REG_IDX_BIT])
      bfs_pkg::REG_RIGIDITY:  cfg_prdata = rigidity_r;
      bfs_pkg::REG_LOOP_MODE: cfg_prdata = {31'd0, loop_mode_r};
      default:                cfg_prdata = '0;
    endcase
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The transaction that ends a fiber must block the next one.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_point) |=> in_stall)
    else $error("input accepted right after the last point of a fiber");

  // A result only appears through the output step of the sequencer.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  // A compute pass always has at least one stored point.
  a_busy_has_points: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (cnt_r != '0))
    else $error("compute pass running with no stored points");

  // The walk never passes the stored point count.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (CW'(idx_r) < cnt_r))
    else $error("point index beyond the stored point count");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for bending_force_stencil_top: fibers of points are streamed in
// and each updated force is compared with an in-bench prediction of the bending stencil.
// Depends on bfs_pkg for the payload structs, the register indexes and the address layout.
`default_nettype none

module tb;

  localparam int CAPACITY    = 64;
  localparam int DIMS        = 3;
  localparam int SETTLE      = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAXV        = 32'h7fff_ffff;
  localparam int MINV        = int'(32'h8000_0000);
  localparam logic [31:0] UNIT_RIGIDITY = 32'h0001_0000;
  localparam logic [31:0] FULL_RIGIDITY = 32'hffff_ffff;

  logic clk = 1'b0;
  logic rst_n;

  logic in_valid;
  logic in_stall;
  bfs_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  bfs_pkg::out_t out_data;

  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [bfs_pkg::PADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Bench copy of the block's state and configuration.
  int pos_mem[CAPACITY][DIMS];
  int frc_mem[CAPACITY][DIMS];
  longint force_sum[CAPACITY][DIMS];
  int stored = 0;
  logic dropped = 1'b0;
  logic [31:0] rigidity_r = '0;
  logic loop_r = 1'b0;
  bfs_pkg::out_t pending_forces[$];

  int mismatches = 0;
  int cycle_count = 0;
  int in_idle_pct = 30;
  int out_stall_pct = 30;

  bending_force_stencil_top #(
    .MAX_POINTS(CAPACITY),
    .DIMENSION(DIMS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  // floor(diff * R / 2^16); the product needs more than 64 bits at full rigidity.
  function automatic longint bend_term(input longint diff);
    logic signed [79:0] wide_diff;
    logic signed [79:0] wide_r;
    logic signed [79:0] prod;
    wide_diff = diff;
    wide_r = {48'd0, rigidity_r};
    prod = wide_diff * wide_r;
    return longint'(prod >>> 16);
  endfunction

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void apply_bend(input int a, input int b, input int c);
    longint diff;
    longint f;
    for (int k = 0; k < DIMS; k++) begin
      diff = longint'(pos_mem[a][k]) - 2 * longint'(pos_mem[b][k]) + longint'(pos_mem[c][k]);
      f = bend_term(diff);
      force_sum[a][k] -= f;
      force_sum[b][k] += 2 * f;
      force_sum[c][k] -= f;
    end
  endfunction

  // Stores one point; the last point of a fiber queues one updated force per stored point.
  function automatic void load_point(input bfs_pkg::in_t p);
    bfs_pkg::out_t r;
    if (stored < CAPACITY) begin
      pos_mem[stored][0] = p.pos_x;
      pos_mem[stored][1] = p.pos_y;
      pos_mem[stored][2] = p.pos_z;
      frc_mem[stored][0] = p.force_in_x;
      frc_mem[stored][1] = p.force_in_y;
      frc_mem[stored][2] = p.force_in_z;
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (!p.last_point) return;
    for (int i = 0; i < stored; i++) begin
      for (int k = 0; k < DIMS; k++) force_sum[i][k] = frc_mem[i][k];
    end
    if (stored >= 3) begin
      for (int i = 0; i + 2 < stored; i++) apply_bend(i, i + 1, i + 2);
      if (loop_r && stored >= 4) begin
        apply_bend(stored - 1, 0, 1);
        apply_bend(stored - 2, stored - 1, 0);
      end
    end
    for (int i = 0; i < stored; i++) begin
      r.force_out_x = clamp_q16(force_sum[i][0]);
      r.force_out_y = clamp_q16(force_sum[i][1]);
      r.force_out_z = clamp_q16(force_sum[i][2]);
      r.point_index = bfs_pkg::IDX_W'(i);
      r.overflow = dropped;
      r.last_result = (i == stored - 1);
      pending_forces.push_back(r);
    end
    stored = 0;
    dropped = 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t: mismatch, %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input int idx);
    if (got !== want)
      report_mismatch($sformatf("point %0d %s: got %h, expected %h", idx, name, got, want));
  endtask

  task automatic check_result(input bfs_pkg::out_t got);
    bfs_pkg::out_t want;
    if (pending_forces.size() == 0) begin
      report_mismatch($sformatf("unexpected result for point %0d", got.point_index));
      return;
    end
    want = pending_forces.pop_front();
    compare_field("force_out_x", got.force_out_x, want.force_out_x, want.point_index);
    compare_field("force_out_y", got.force_out_y, want.force_out_y, want.point_index);
    compare_field("force_out_z", got.force_out_z, want.force_out_z, want.point_index);
    compare_field("point_index", got.point_index, want.point_index, want.point_index);
    compare_field("overflow", got.overflow, want.overflow, want.point_index);
    compare_field("last_result", got.last_result, want.last_result, want.point_index);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // ---------------------------------------------------------------- driving

  function automatic int gap_cycles(input int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    return n;
  endfunction

  task automatic send_point(input bfs_pkg::in_t p);
    int n;
    n = gap_cycles(in_idle_pct);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    load_point(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
  endtask

  // Leaves a quiet stretch after every expected result has come.
  task automatic settle();
    drain_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= bfs_pkg::PADDR_W'(reg_sel) << bfs_pkg::REG_IDX_BIT;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_sel == bfs_pkg::REG_RIGIDITY) rigidity_r = value;
    else loop_r = value[0];
  endtask

  task automatic configure(input logic [31:0] rigidity, input logic ring);
    write_reg(bfs_pkg::REG_RIGIDITY, rigidity);
    write_reg(bfs_pkg::REG_LOOP_MODE, {31'd0, ring});
  endtask

  function automatic bfs_pkg::in_t point_of(input int x, input int y, input int z,
                                            input int fx, input int fy, input int fz,
                                            input logic last);
    bfs_pkg::in_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    p.force_in_x = fx;
    p.force_in_y = fy;
    p.force_in_z = fz;
    p.last_point = last;
    return p;
  endfunction

  function automatic int rand_q16();
    case ($urandom_range(3))
      0: return int'($urandom);
      1: return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      2: return int'($urandom) >>> 8;
      default: begin
        case ($urandom_range(3))
          0: return MAXV;
          1: return MINV;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic bfs_pkg::in_t make_point(input logic last);
    return point_of(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                    last);
  endfunction

  function automatic logic [31:0] rand_rigidity();
    case ($urandom_range(3))
      0: return $urandom_range(32'h0004_0000);
      1: return $urandom;
      2: return $urandom_range(32'h0000_ffff);
      default: return $urandom_range(1) ? FULL_RIGIDITY : 32'd0;
    endcase
  endfunction

  function automatic int fiber_size();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 24);
    return $urandom_range(CAPACITY - 4, CAPACITY);
  endfunction

  // ---------------------------------------------------------------- tests

  // Fibers of one and two points pass their forces through untouched.
  task automatic test_short_fibers();
    configure(UNIT_RIGIDITY, 1'b0);
    send_point(point_of(MAXV, MINV, 0, MAXV, MINV, -1, 1'b1));
    send_point(point_of(MINV, MAXV, -1, MINV, MAXV, 0, 1'b0));
    send_point(point_of(12345, -6789, 32'h0001_0000, -1, 1, 77, 1'b1));
    settle();
  endtask

  // Open fibers: a half rigidity with odd differences checks rounding toward minus
  // infinity, then full rigidity on alternating extremes drives every sum to saturation.
  task automatic test_open_stencil();
    configure(32'h0000_8000, 1'b0);
    send_point(point_of(3, -5, 32'h0001_2345, 100, -100, 0, 1'b0));
    send_point(point_of(0, 0, 0, 0, 0, 0, 1'b0));
    send_point(point_of(-4, 7, -1, -3, 3, 32'h0000_ffff, 1'b1));
    settle();
    configure(FULL_RIGIDITY, 1'b0);
    send_point(point_of(MAXV, MINV, MAXV, MAXV, MINV, MAXV, 1'b0));
    send_point(point_of(MINV, MAXV, MINV, MINV, MAXV, MINV, 1'b0));
    send_point(point_of(MAXV, MINV, MAXV, MINV, MAXV, 0, 1'b1));
    settle();
  endtask

  // Ring mode: three points get no wrap triplets, four and five points do.
  task automatic test_ring_closure();
    configure(FULL_RIGIDITY, 1'b1);
    send_point(point_of(1, 2, 3, 0, 0, 0, 1'b0));
    send_point(point_of(-7, 5, 0, 10, -10, 1, 1'b0));
    send_point(point_of(2, -9, 4, -1, 1, 0, 1'b1));
    settle();
    configure(UNIT_RIGIDITY, 1'b1);
    send_point(point_of(32'h0001_0000, 0, 0, 0, 0, 0, 1'b0));
    send_point(point_of(0, 32'h0001_0000, 0, 0, 0, 0, 1'b0));
    send_point(point_of(-32'sh0001_0000, 0, 32'h0000_8000, 5, 5, 5, 1'b0));
    send_point(point_of(0, -32'sh0001_0000, -32'sh0000_8000, -5, -5, -5, 1'b1));
    settle();
    configure(32'h0001_8000, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_point(point_of(rand_q16() >>> 12, rand_q16() >>> 12, rand_q16() >>> 12,
                          rand_q16(), rand_q16(), rand_q16(), i == 4));
    end
    settle();
    configure(32'd0, 1'b0);
    for (int i = 0; i < 3; i++) send_point(make_point(i == 2));
    settle();
  endtask

  // Two points beyond capacity are dropped, the second one carrying the end marker.
  // Runs without idling on either side.
  task automatic test_capacity();
    configure(rand_rigidity(), 1'b1);
    in_idle_pct = 0;
    out_stall_pct = 0;
    for (int i = 0; i < CAPACITY + 2; i++) send_point(make_point(i == CAPACITY + 1));
    drain_results();
    in_idle_pct = 30;
    out_stall_pct = 30;
    settle();
  endtask

  task automatic test_random_fibers(input int item_goal);
    int sent;
    int size;
    sent = 0;
    while (sent < item_goal) begin
      size = fiber_size();
      for (int k = 0; k < size; k++) send_point(make_point(k == size - 1));
      sent += size;
      if ($urandom_range(3) == 0) drain_results();
    end
    settle();
  endtask

  task automatic test_random_phases();
    configure(rand_rigidity(), 1'b0);
    test_random_fibers(30);
    configure(rand_rigidity(), 1'b1);
    test_random_fibers(30);
    configure(FULL_RIGIDITY, 1'($urandom_range(1)));
    test_random_fibers(30);
    configure($urandom_range(32'h0002_0000), 1'b1);
    test_random_fibers(30);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_short_fibers();
    test_open_stencil();
    test_ring_closure();
    test_capacity();
    test_random_phases();
    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
